// File: rtl/u8cpd_pkg.sv
`default_nettype none

package u8cpd_pkg;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EVAL  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture the new byte into the working buffer
        logic take;       // latch the current decision as pending result
        logic push;       // move pending result into the output register
        logic push_last;  // pushed result is the last one of this byte
        logic compact;    // keep unconsumed bytes for the next byte
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic done;        // nothing left to decide for this byte
        logic pend_valid;  // a result waits in the pending slot
        logic out_free;    // output register can take a result this cycle
    } stat_t;

    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;
    localparam logic [20:0] MIN_2BYTE   = 21'h000080;
    localparam logic [20:0] MIN_3BYTE   = 21'h000800;
    localparam logic [20:0] MIN_4BYTE   = 21'h010000;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;

    // Sequence length announced by a lead byte, 0 for an invalid lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            len = 3'd0;
            if (b < 8'h80)
                len = 3'd1;
            else if (b >= 8'hC2 && b < 8'hE0)
                len = 3'd2;
            else if (b >= 8'hE0 && b < 8'hF0)
                len = 3'd3;
            else if (b >= 8'hF0 && b <= 8'hF4)
                len = 3'd4;
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/u8cpd_datapath.sv
`default_nettype none

module u8cpd_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      byte_in,
    input  wire logic            end_of_text,
    input  wire u8cpd_pkg::cmd_t cmd,
    output u8cpd_pkg::stat_t     stat,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [20:0]          code_point,
    output logic                 was_invalid,
    output logic                 run_last,
    output logic                 text_last
);

    // Working buffer: held bytes followed by the new byte
    logic [7:0]  buf_reg [4];
    logic [2:0]  n_reg;
    logic [2:0]  pos_reg;
    logic        eot_reg;
    logic [1:0]  held_cnt_reg;

    // Pending result slot
    logic        pend_valid_reg;
    logic [20:0] pend_code_reg;
    logic        pend_bad_reg;

    // Output register
    logic        out_valid_reg;
    logic [20:0] out_code_reg;
    logic        out_bad_reg;
    logic        out_run_last_reg;
    logic        out_text_last_reg;

    // Decision logic at the current position
    logic [7:0]  first;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [2:0]  len;
    logic [2:0]  avail;
    logic [2:0]  upto;
    logic        at_end;
    logic        cont_bad;
    logic        is_short;
    logic        range_bad;
    logic [20:0] code;
    logic        res_bad;
    logic [20:0] res_code;
    logic [2:0]  adv;
    logic [1:0]  idx;

    always_comb
    begin
        first  = buf_reg[pos_reg[1:0]];
        b1     = buf_reg[pos_reg[1:0] + 2'd1];
        b2     = buf_reg[pos_reg[1:0] + 2'd2];
        b3     = buf_reg[pos_reg[1:0] + 2'd3];
        len    = u8cpd_pkg::lead_len(first);
        avail  = n_reg - pos_reg;
        at_end = (pos_reg >= n_reg);
        upto   = (len < avail) ? len : avail;

        // continuation bytes that are present must be 10xxxxxx
        cont_bad = 1'b0;
        for (int i = 1; i < 4; i++)
        begin
            idx = pos_reg[1:0] + 2'(i);
            if (3'(i) < upto && buf_reg[idx][7:6] != 2'b10)
                cont_bad = 1'b1;
        end
        is_short = (avail < len);

        case (len)
            3'd1:    code = {13'd0, first};
            3'd2:    code = {10'd0, first[4:0], b1[5:0]};
            3'd3:    code = {5'd0, first[3:0], b1[5:0], b2[5:0]};
            3'd4:    code = {first[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: code = 21'd0;
        endcase

        // overlong, out of range, surrogate
        range_bad = (len == 3'd2 && code < u8cpd_pkg::MIN_2BYTE)
                 || (len == 3'd3 && code < u8cpd_pkg::MIN_3BYTE)
                 || (len == 3'd4 && code < u8cpd_pkg::MIN_4BYTE)
                 || (code > u8cpd_pkg::MAX_SCALAR)
                 || (code >= u8cpd_pkg::SURR_LO && code <= u8cpd_pkg::SURR_HI);

        res_bad  = (len == 3'd0) || cont_bad || is_short || range_bad;
        res_code = res_bad ? u8cpd_pkg::REPLACEMENT : code;
        adv      = res_bad ? 3'd1 : len;

        stat.done       = at_end
                       || (len != 3'd0 && !cont_bad && is_short && !eot_reg);
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    // Buffer and position control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg        <= 3'd0;
            pos_reg      <= 3'd0;
            eot_reg      <= 1'b0;
            held_cnt_reg <= 2'd0;
        end
        else
        begin
            if (cmd.load)
            begin
                n_reg   <= {1'b0, held_cnt_reg} + 3'd1;
                pos_reg <= 3'd0;
                eot_reg <= end_of_text;
            end
            else if (cmd.take)
                pos_reg <= pos_reg + adv;
            if (cmd.compact)
                held_cnt_reg <= 2'(n_reg - pos_reg);
        end
    end

    // Buffer bytes: payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            buf_reg[held_cnt_reg] <= byte_in;
        else if (cmd.compact)
        begin
            for (int i = 0; i < 3; i++)
                buf_reg[i] <= buf_reg[pos_reg[1:0] + 2'(i)];
        end
    end

    // Pending slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (cmd.take)
            pend_valid_reg <= 1'b1;
        else if (cmd.push)
            pend_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pend_code_reg <= res_code;
            pend_bad_reg  <= res_bad;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.push)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_code_reg      <= pend_code_reg;
            out_bad_reg       <= pend_bad_reg;
            out_run_last_reg  <= cmd.push_last;
            out_text_last_reg <= cmd.push_last & eot_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_point  = out_code_reg;
    assign was_invalid = out_bad_reg;
    assign run_last    = out_run_last_reg;
    assign text_last   = out_text_last_reg;

    // A push never overwrites a result still waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> stat.out_free)
        else $error("push into busy output register");

    // Position never runs past the end of the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= n_reg)
        else $error("position beyond buffer fill");

    // End of text leaves nothing held
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.compact && eot_reg) |=> (held_cnt_reg == 2'd0))
        else $error("bytes held across end of text");

    // A take with a full pending slot must push it out in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && pend_valid_reg) |-> cmd.push)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: rtl/u8cpd_ctrl.sv
`default_nettype none

module u8cpd_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire u8cpd_pkg::stat_t stat,
    output u8cpd_pkg::cmd_t       cmd
);

    u8cpd_pkg::state_t state_reg;
    u8cpd_pkg::state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            u8cpd_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = u8cpd_pkg::ST_EVAL;
                end
            end
            u8cpd_pkg::ST_EVAL:
            begin
                if (stat.done)
                begin
                    if (stat.pend_valid)
                        state_next = u8cpd_pkg::ST_FLUSH;
                    else
                    begin
                        cmd.compact = 1'b1;
                        state_next  = u8cpd_pkg::ST_IDLE;
                    end
                end
                else if (!stat.pend_valid)
                    cmd.take = 1'b1;
                else if (stat.out_free)
                begin
                    cmd.take = 1'b1;
                    cmd.push = 1'b1;
                end
            end
            u8cpd_pkg::ST_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    cmd.compact   = 1'b1;
                    state_next    = u8cpd_pkg::ST_IDLE;
                end
            end
            default:
                state_next = u8cpd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= u8cpd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // A flush only happens with a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == u8cpd_pkg::ST_FLUSH) |-> stat.pend_valid)
        else $error("flush with empty pending slot");

    // Idle means no result left over from the previous byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == u8cpd_pkg::ST_IDLE) |-> !stat.pend_valid)
        else $error("pending result left while idle");

    // Every accepted byte is evaluated in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == u8cpd_pkg::ST_EVAL))
        else $error("load not followed by evaluation");

endmodule

`default_nettype wire

// File: rtl/utf8_codepoint_decoder_unit.sv
`default_nettype none

// Channel | Signals                                          | Direction
// input   | in_valid, in_stall, byte_in, end_of_text         | byte stream in
// output  | out_valid, out_stall, code_point, was_invalid,   | code points out
//         | run_last, text_last                              |
//
// One byte at a time: ST_IDLE accepts the byte, ST_EVAL decides each result
// (0 to 4) and then sees the byte finished, and ST_FLUSH pushes the last
// result when the byte produced results.
// The single decode unit steps through the 4-byte working buffer one sequence
// per cycle while the output is not stalled; output stalls hold it in place.
// Reset (rst_n low, asynchronous) empties the held bytes and output register.

module utf8_codepoint_decoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  byte_in,
    input  wire logic        end_of_text,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [20:0]      code_point,
    output logic             was_invalid,
    output logic             run_last,
    output logic             text_last
);

    u8cpd_pkg::cmd_t  cmd;
    u8cpd_pkg::stat_t stat;

    u8cpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    u8cpd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_in     (byte_in),
        .end_of_text (end_of_text),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .was_invalid (was_invalid),
        .run_last    (run_last),
        .text_last   (text_last)
    );

endmodule

`default_nettype wire
